FILE: rtl/slen_pkg.sv
`default_nettype none
package slen_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int VALUE_W    = 32;
    localparam int MODE_W     = 3;
    localparam int POS_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 9;

    // mode codes as they arrive on the input port
    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REM_FIRST = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REM_LAST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REM_POS   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOPOS    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REM_FIRST,
        OP_REM_LAST,
        OP_REM_POS,
        OP_CLEAR,
        OP_SEARCH
    } t_op_code;

    typedef struct packed {
        t_op_code                  op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_op;

endpackage
`default_nettype wire

FILE: rtl/slen_front.sv
`default_nettype none
module slen_front (
    input  wire                                 i_push,
    input  wire [slen_pkg::MODE_W-1:0]          i_mode,
    input  wire signed [slen_pkg::VALUE_W-1:0]  i_value,
    input  wire [slen_pkg::POS_W-1:0]           i_position,
    input  wire                                 i_q_full,
    output logic                                o_q_push,
    output slen_pkg::t_op                       o_q_word
);

    // classify the incoming word into an operation
    always_comb begin
        o_q_word.value    = i_value;
        o_q_word.position = i_position;
        case (i_mode)
            slen_pkg::MODE_INSERT:    o_q_word.op = slen_pkg::OP_INSERT;
            slen_pkg::MODE_REM_FIRST: o_q_word.op = slen_pkg::OP_REM_FIRST;
            slen_pkg::MODE_REM_LAST:  o_q_word.op = slen_pkg::OP_REM_LAST;
            slen_pkg::MODE_REM_POS:   o_q_word.op = slen_pkg::OP_REM_POS;
            slen_pkg::MODE_CLEAR:     o_q_word.op = slen_pkg::OP_CLEAR;
            slen_pkg::MODE_SEARCH:    o_q_word.op = slen_pkg::OP_SEARCH;
            default:                  o_q_word.op = slen_pkg::OP_NONE;
        endcase
    end

    assign o_q_push = i_push && !i_q_full;

endmodule
`default_nettype wire

FILE: rtl/slen_queue.sv
`default_nettype none
module slen_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  slen_pkg::t_op  i_word,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output slen_pkg::t_op  o_word
);

    slen_pkg::t_op r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_word  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // two-word queue storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/slen_back.sv
`default_nettype none
module slen_back #(
    parameter int DEPTH = slen_pkg::DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    input  slen_pkg::t_op                       i_word,
    output logic                                o_take,
    output logic                                o_empty,
    input  wire                                 i_pop,
    output logic [slen_pkg::STATUS_W-1:0]       o_status,
    output logic [slen_pkg::POS_W-1:0]          o_found_position,
    output logic [slen_pkg::COUNT_W-1:0]        o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [slen_pkg::VALUE_W-1:0] r_cell [DEPTH];
    logic signed [slen_pkg::VALUE_W-1:0] n_cell [DEPTH];
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    logic                                r_out_valid;
    logic [slen_pkg::STATUS_W-1:0]       r_status;
    logic [slen_pkg::STATUS_W-1:0]       n_status;
    logic [slen_pkg::POS_W-1:0]          r_found;
    logic [slen_pkg::POS_W-1:0]          n_found;
    logic [slen_pkg::COUNT_W-1:0]        r_count_out;

    logic [DEPTH-1:0]                    lt;
    logic [DEPTH-1:0]                    eq;
    logic [slen_pkg::POS_W-1:0]          hit_pos;
    logic [slen_pkg::POS_W-1:0]          rem_pos;
    logic                                is_full;
    logic                                is_empty;
    logic                                pos_bad;
    logic                                do_ins;
    logic                                do_rem;

    assign o_take   = i_valid && (!r_out_valid || i_pop);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);
    assign pos_bad  = (slen_pkg::COUNT_W'(i_word.position) >= slen_pkg::COUNT_W'(r_count));

    // per-cell compares against the operand
    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            lt[i] = (CW'(i) < r_count) && (i_word.value > r_cell[i]);
            eq[i] = (CW'(i) < r_count) && (i_word.value == r_cell[i]);
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (eq[i] && (i == 0 || !eq[(i == 0) ? 0 : i-1])) begin
                hit_pos = hit_pos | slen_pkg::POS_W'(i);
            end
        end
    end

    // status and count of the operation
    always_comb begin
        n_status = slen_pkg::ST_OK;
        n_found  = '0;
        n_count  = r_count;
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        rem_pos  = '0;
        case (i_word.op)
            slen_pkg::OP_INSERT: begin
                if (is_full) begin
                    n_status = slen_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            slen_pkg::OP_REM_FIRST: begin
                if (is_empty) begin
                    n_status = slen_pkg::ST_EMPTY;
                end else begin
                    do_rem  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            slen_pkg::OP_REM_LAST: begin
                if (is_empty) begin
                    n_status = slen_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            slen_pkg::OP_REM_POS: begin
                if (is_empty) begin
                    n_status = slen_pkg::ST_EMPTY;
                end else if (pos_bad) begin
                    n_status = slen_pkg::ST_NOPOS;
                end else begin
                    do_rem  = 1'b1;
                    rem_pos = i_word.position;
                    n_count = r_count - CW'(1);
                end
            end
            slen_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            slen_pkg::OP_SEARCH: begin
                if (is_empty) begin
                    n_status = slen_pkg::ST_EMPTY;
                end else if (|eq) begin
                    n_found = hit_pos;
                end else begin
                    n_status = slen_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                n_status = slen_pkg::ST_OK;
            end
        endcase
    end

    // compare-and-shift cell update
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_cell[i] = r_cell[i];
            if (do_ins && !lt[i]) begin
                if (i == 0 || lt[(i == 0) ? 0 : i-1]) begin
                    n_cell[i] = i_word.value;
                end else begin
                    n_cell[i] = r_cell[(i == 0) ? 0 : i-1];
                end
            end else if (do_rem && (slen_pkg::COUNT_W'(i) >= slen_pkg::COUNT_W'(rem_pos))
                         && (i < DEPTH - 1)) begin
                n_cell[i] = r_cell[(i < DEPTH - 1) ? i+1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cell <= n_cell;
        end
    end

    // table count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_status    <= n_status;
            r_found     <= n_found;
            r_count_out <= slen_pkg::COUNT_W'(n_count);
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_entry_count    = r_count_out;

endmodule
`default_nettype wire

FILE: rtl/sorted_list_engine.sv
// Sorted list engine: keeps up to DEPTH signed 32-bit values in ascending
// order and carries out one operation per word (insert, remove smallest,
// remove largest, remove at position, clear, search), giving one result word
// for each. A two-word queue sits between the decode front and the cell array,
// and every cell compares and shifts in parallel, so the array finishes an
// operation as it takes it: one word per cycle is sustained while each result
// word is popped as it shows, and an input word passes the queue register and
// then the result register before its result shows on the output ports.
`default_nettype none
module sorted_list_engine #(
    parameter int DEPTH = slen_pkg::DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_push,
    output logic                                o_full,
    input  wire [slen_pkg::MODE_W-1:0]          i_mode,
    input  wire signed [slen_pkg::VALUE_W-1:0]  i_value,
    input  wire [slen_pkg::POS_W-1:0]           i_position,
    output logic                                o_empty,
    input  wire                                 i_pop,
    output logic [slen_pkg::STATUS_W-1:0]       o_status,
    output logic [slen_pkg::POS_W-1:0]          o_found_position,
    output logic [slen_pkg::COUNT_W-1:0]        o_entry_count
);

    logic          q_push;
    slen_pkg::t_op q_in;
    logic          q_valid;
    slen_pkg::t_op q_out;
    logic          q_take;

    slen_front u_front (
        .i_push     (i_push),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .i_position (i_position),
        .i_q_full   (o_full),
        .o_q_push   (q_push),
        .o_q_word   (q_in)
    );

    slen_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in),
        .o_full  (o_full),
        .i_pop   (q_take),
        .o_valid (q_valid),
        .o_word  (q_out)
    );

    slen_back #(.DEPTH(DEPTH)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_word           (q_out),
        .o_take           (q_take),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

endmodule
`default_nettype wire

FILE: rtl/slen_checker.sv
`default_nettype none
module slen_checker #(
    parameter int DEPTH = slen_pkg::DEPTH_DEF
) (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               o_empty,
    input wire                               i_pop,
    input wire [slen_pkg::STATUS_W-1:0]      o_status,
    input wire [slen_pkg::POS_W-1:0]         o_found_position,
    input wire [slen_pkg::COUNT_W-1:0]       o_entry_count
);

    // nothing waits on the output right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result shown after reset");

    // count never exceeds the table size
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_entry_count <= slen_pkg::COUNT_W'(DEPTH)))
        else $error("entry count beyond depth");

    // position only reported by a successful search
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status != slen_pkg::ST_OK) |-> (o_found_position == '0))
        else $error("found position on failed operation");

    // full status only with a full table
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status == slen_pkg::ST_FULL)
            |-> (o_entry_count == slen_pkg::COUNT_W'(DEPTH)))
        else $error("full status with room left");

    // waiting result status and entry count hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_status)
            && $stable(o_entry_count)))
        else $error("result word changed while waiting");

endmodule

bind sorted_list_engine slen_checker #(.DEPTH(DEPTH)) u_slen_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_empty          (o_empty),
    .i_pop            (i_pop),
    .o_status         (o_status),
    .o_found_position (o_found_position),
    .o_entry_count    (o_entry_count)
);
`default_nettype wire
